### hw/rtl/stereo_peaking_eq_biquad_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo peaking EQ biquad
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAKING_EQ_BIQUAD_TOP_ASSERT_SVH
`define STEREO_PEAKING_EQ_BIQUAD_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SPEQ_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SPEQ_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SPEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/speq_pkg.sv
// ----------------------------------------------------------------------------
// Stereo peaking EQ biquad package
// Sample width, register indexes and the payload types of both channels.
// ----------------------------------------------------------------------------
package speq_pkg;

   // Audio sample width, signed Q1.(SAMPLE_WIDTH-1).
   localparam int SAMPLE_WIDTH = 24;

   // Default coefficient width, signed Q8.(COEF_WIDTH-8).
   localparam int COEF_WIDTH_DEF = 32;

   // Number of audio channels in one frame.
   localparam int NUM_CH = 2;

   // Configuration register index.
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE  = 3'd0,
      CSR_COEF_B0 = 3'd1,
      CSR_COEF_B1 = 3'd2,
      CSR_COEF_B2 = 3'd3,
      CSR_COEF_A1 = 3'd4,
      CSR_COEF_A2 = 3'd5
   } csr_index_type;

   // One stereo input frame.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_in;
      logic signed [SAMPLE_WIDTH-1:0] right_in;
      logic                           frame_last;
   } speq_req_type;

   // One filtered stereo frame.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
      logic                           out_last;
   } speq_rsp_type;

endpackage

### hw/rtl/stereo_peaking_eq_biquad_top.sv
// ----------------------------------------------------------------------------
// Stereo peaking EQ biquad
// Direct Form I second-order IIR section applied to both channels of each
// frame with five shared coefficients, rounded and saturated to the sample
// width, with a bypass when filtering is disabled.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   speq_req_type (one frame)
//   rsp_      out        rsp_valid/rsp_ready   speq_rsp_type (one frame)
//   csr_      in         csr_we                csr_index, csr_wdata
//
// One frame per clock cycle sustained while results are taken. A frame taken
// goes into the input register and moves on into the result register, from
// which it shows on rsp_ and leaves when rsp_ready is high.
// The whole filter sum for both channels, with the output history fed back
// from the previous frame, is evaluated between those two registers.
// Reset is synchronous and sets the valid flags, the history and the
// configuration registers to their defaults; no clearing pass is needed.
// A stalled result holds in the result register while one more frame waits
// in the input register; req_ready drops only when both are occupied and the
// result is not taken in that cycle.
// ----------------------------------------------------------------------------
module stereo_peaking_eq_biquad_top
   import speq_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  speq_req_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output speq_rsp_type               rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   // Fraction bits of a coefficient below the sample LSB.
   localparam int CFRAC  = COEF_WIDTH - 8;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W  = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;
   localparam int RW     = ACC_W - CFRAC;

   localparam logic signed [ACC_W-1:0] RND_HALF =
      {{(ACC_W - CFRAC){1'b0}}, 1'b1, {(CFRAC - 1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      {{7{1'b0}}, 1'b1, {CFRAC{1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Configuration registers.
   logic                         enable_ff;
   logic signed [COEF_WIDTH-1:0] coef_b0_ff;
   logic signed [COEF_WIDTH-1:0] coef_b1_ff;
   logic signed [COEF_WIDTH-1:0] coef_b2_ff;
   logic signed [COEF_WIDTH-1:0] coef_a1_ff;
   logic signed [COEF_WIDTH-1:0] coef_a2_ff;

   // Pipeline registers.
   logic         s1_valid_ff;
   speq_req_type s1_data_ff;
   logic         rsp_valid_ff;
   speq_rsp_type rsp_data_ff;
   speq_rsp_type rsp_data_in;
   logic         advance;

   // Per-channel history.
   logic signed [SAMPLE_WIDTH-1:0] in_d1_ff  [NUM_CH];
   logic signed [SAMPLE_WIDTH-1:0] in_d2_ff  [NUM_CH];
   logic signed [SAMPLE_WIDTH-1:0] out_d1_ff [NUM_CH];
   logic signed [SAMPLE_WIDTH-1:0] out_d2_ff [NUM_CH];

   logic signed [SAMPLE_WIDTH-1:0] x_ch   [NUM_CH];
   logic signed [SAMPLE_WIDTH-1:0] y_ch   [NUM_CH];
   logic signed [SAMPLE_WIDTH-1:0] out_ch [NUM_CH];

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         coef_b0_ff <= COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            CSR_COEF_B0: coef_b0_ff <= csr_wdata;
            CSR_COEF_B1: coef_b1_ff <= csr_wdata;
            CSR_COEF_B2: coef_b2_ff <= csr_wdata;
            CSR_COEF_A1: coef_a1_ff <= csr_wdata;
            CSR_COEF_A2: coef_a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A frame moves from the input register to the result register when the
   // result register is empty or its transaction completes this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign x_ch[0] = s1_data_ff.left_in;
   assign x_ch[1] = s1_data_ff.right_in;

   // Filter section for each channel.
   for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
      logic signed [PROD_W-1:0] prod_b0;
      logic signed [PROD_W-1:0] prod_b1;
      logic signed [PROD_W-1:0] prod_b2;
      logic signed [PROD_W-1:0] prod_a1;
      logic signed [PROD_W-1:0] prod_a2;
      logic signed [ACC_W-1:0]  acc;
      logic signed [RW-1:0]     acc_shift;
      logic                     in_range;

      assign prod_b0 = coef_b0_ff * x_ch[g];
      assign prod_b1 = coef_b1_ff * in_d1_ff[g];
      assign prod_b2 = coef_b2_ff * in_d2_ff[g];
      assign prod_a1 = coef_a1_ff * out_d1_ff[g];
      assign prod_a2 = coef_a2_ff * out_d2_ff[g];

      // Sum with half an LSB added, then floor shift (round half up).
      assign acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
                 - ACC_W'(prod_a1) - ACC_W'(prod_a2) + RND_HALF;
      assign acc_shift = acc[ACC_W-1:CFRAC];

      // Clamp to the signed sample range.
      assign in_range = (&acc_shift[RW-1:SAMPLE_WIDTH-1])
                     || !(|acc_shift[RW-1:SAMPLE_WIDTH-1]);
      assign y_ch[g]   = in_range ? acc_shift[SAMPLE_WIDTH-1:0]
                       : (acc_shift[RW-1] ? SAT_LO : SAT_HI);
      assign out_ch[g] = enable_ff ? y_ch[g] : x_ch[g];
   end

   always_comb begin
      rsp_data_in.left_out  = out_ch[0];
      rsp_data_in.right_out = out_ch[1];
      rsp_data_in.out_last  = s1_data_ff.frame_last;
   end

   // History advances only for frames that are filtered.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            in_d1_ff[i]  <= '0;
            in_d2_ff[i]  <= '0;
            out_d1_ff[i] <= '0;
            out_d2_ff[i] <= '0;
         end
      end else if (advance && enable_ff) begin
         for (int i = 0; i < NUM_CH; i++) begin
            in_d2_ff[i]  <= in_d1_ff[i];
            in_d1_ff[i]  <= x_ch[i];
            out_d2_ff[i] <= out_d1_ff[i];
            out_d1_ff[i] <= y_ch[i];
         end
      end
   end

   // Input register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hw/rtl/speq_checker.sv
// ----------------------------------------------------------------------------
// Stereo peaking EQ biquad port checker
// Tracks frames in flight from the port handshakes and checks that each result
// has a frame behind it, capacity, readiness when empty, reset and output hold behavior.
// ----------------------------------------------------------------------------
`include "stereo_peaking_eq_biquad_top_assert.svh"

module speq_checker
   import speq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input speq_rsp_type rsp_data
);

   // The block holds at most one frame in each of its two registers.
   localparam logic [1:0] MAX_IN_FLIGHT = 2'd2;

   logic [1:0] in_flight_ff;
   logic [1:0] in_flight_in;
   logic       in_xact;
   logic       out_xact;
   logic       pending;
   logic       rsp_stall;
   logic [$bits(speq_rsp_type):0] rsp_word;

   assign in_xact   = req_valid && req_ready;
   assign out_xact  = rsp_valid && rsp_ready;
   assign pending   = (in_flight_ff != 2'd0);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_valid, rsp_data};

   // Count of frames taken whose results are not yet delivered.
   always_comb begin
      unique case ({in_xact, out_xact})
         2'b10:   in_flight_in = in_flight_ff + 2'd1;
         2'b01:   in_flight_in = in_flight_ff - 2'd1;
         default: in_flight_in = in_flight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `SPEQ_ASSERT_IMPL(a_rsp_has_source, clock, reset, rsp_valid, pending, "result with no frame")
   `SPEQ_ASSERT_ALWAYS(a_capacity, clock, reset, in_flight_ff <= MAX_IN_FLIGHT, "over capacity")
   `SPEQ_ASSERT_IMPL(a_empty_ready, clock, reset, !pending, req_ready, "empty block not ready")
   `SPEQ_ASSERT_IMPL(a_reset_clear, clock, reset, $past(reset), !rsp_valid, "valid after reset")
   `SPEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "result not held")

endmodule

bind stereo_peaking_eq_biquad_top speq_checker u_speq_checker (.*);
